// ----- src/cets_pkg.sv -----
// Shared types, constants and helpers for the event timing select unit.
`default_nettype none
package cets_pkg;

  localparam int ID_W     = 10;
  localparam int ENERGY_W = 16;
  localparam int TIME_W   = 18;
  localparam int PROD_W   = ENERGY_W + 1 + TIME_W;
  localparam int QSTEP_W  = $clog2(TIME_W);

  typedef logic [ID_W-1:0]            id_t;
  typedef logic [ENERGY_W-1:0]        energy_t;
  typedef logic signed [TIME_W-1:0]   time_t;
  typedef logic [1:0]                 method_t;
  typedef logic [1:0]                 region_t;
  typedef logic [1:0]                 quality_t;
  typedef logic [1:0]                 cfg_idx_t;

  localparam time_t   TIME_SENTINEL = 18'sd39996;
  localparam id_t     FORWARD_LIMIT = 10'd81;
  localparam id_t     BARREL_LIMIT  = 10'd513;

  localparam method_t METHOD_EARLIEST  = 2'd0;
  localparam method_t METHOD_ENERGETIC = 2'd1;

  localparam region_t REGION_FORWARD  = 2'd0;
  localparam region_t REGION_BARREL   = 2'd1;
  localparam region_t REGION_BACKWARD = 2'd2;

  localparam quality_t QUALITY_NONE = 2'd0;
  localparam quality_t QUALITY_LOW  = 2'd1;
  localparam quality_t QUALITY_MID  = 2'd2;
  localparam quality_t QUALITY_HIGH = 2'd3;

  localparam cfg_idx_t CFG_IDX_METHOD   = 2'd0;
  localparam cfg_idx_t CFG_IDX_THR_LOW  = 2'd1;
  localparam cfg_idx_t CFG_IDX_THR_HIGH = 2'd2;

  localparam method_t RST_METHOD   = METHOD_EARLIEST;
  localparam energy_t RST_THR_LOW  = 16'd1024;
  localparam energy_t RST_THR_HIGH = 16'd20480;

  localparam int EVQ_DEPTH = 2;
  localparam int EVQ_PTR_W = 1;
  localparam int EVQ_CNT_W = 2;

  typedef struct packed {
    method_t method;
    energy_t thr_low;
    energy_t thr_high;
  } cfg_t;

  typedef struct packed {
    time_t   earliest_time;
    id_t     earliest_id;
    energy_t earliest_energy;
    id_t     top_id;
    logic    any_hit;
  } evt_rec_t;

  typedef struct packed {
    time_t    event_time;
    region_t  region;
    quality_t quality_flag;
    id_t      chosen_cell_id;
    energy_t  chosen_cell_energy;
    logic     divide_error;
  } result_t;

  function automatic region_t region_of(input id_t id);
    region_t r;
    if (id < FORWARD_LIMIT) begin
      r = REGION_FORWARD;
    end else if (id < BARREL_LIMIT) begin
      r = REGION_BARREL;
    end else begin
      r = REGION_BACKWARD;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/cets_front.sv -----
// Front end: takes hits and tracks earliest, most energetic and top energy list.
`default_nettype none
module cets_front #(
  parameter int TOP_COUNT = 3
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   acc,
  input  wire logic                                   hit_present,
  input  wire logic                                   last_of_event,
  input  wire cets_pkg::id_t                          cell_id,
  input  wire cets_pkg::energy_t                      cell_energy,
  input  wire cets_pkg::time_t                        cell_time,
  output logic                                        q_push,
  output cets_pkg::evt_rec_t                          q_rec,
  output cets_pkg::energy_t [TOP_COUNT-1:0]           q_top_e,
  output cets_pkg::time_t   [TOP_COUNT-1:0]           q_top_t
);

  cets_pkg::time_t                    e_time_r, e_time_nxt;
  cets_pkg::id_t                      e_id_r, e_id_nxt;
  cets_pkg::energy_t                  e_energy_r, e_energy_nxt;
  cets_pkg::id_t                      top_id_r, top_id_nxt;
  logic                               any_r, any_nxt;
  cets_pkg::energy_t [TOP_COUNT-1:0]  top_e_r, top_e_nxt;
  cets_pkg::time_t   [TOP_COUNT-1:0]  top_t_r, top_t_nxt;
  logic              [TOP_COUNT-1:0]  gt, eq;
  logic                               hit, earlier, ins;

  assign hit     = acc & hit_present;
  assign earlier = $signed(cell_time) < $signed(e_time_r);
  assign ins     = hit && (cell_energy != '0) && !(|eq);

  genvar k;
  generate
    for (k = 0; k < TOP_COUNT; k++) begin : g_top
      assign gt[k] = cell_energy > top_e_r[k];
      assign eq[k] = cell_energy == top_e_r[k];
      if (k == 0) begin : g_head
        always_comb begin
          top_e_nxt[k] = top_e_r[k];
          top_t_nxt[k] = top_t_r[k];
          if (ins && gt[k]) begin
            top_e_nxt[k] = cell_energy;
            top_t_nxt[k] = cell_time;
          end
        end
      end else begin : g_tail
        always_comb begin
          top_e_nxt[k] = top_e_r[k];
          top_t_nxt[k] = top_t_r[k];
          if (ins && gt[k-1]) begin
            top_e_nxt[k] = top_e_r[k-1];
            top_t_nxt[k] = top_t_r[k-1];
          end else if (ins && gt[k]) begin
            top_e_nxt[k] = cell_energy;
            top_t_nxt[k] = cell_time;
          end
        end
      end
    end
  endgenerate

  always_comb begin
    e_time_nxt   = e_time_r;
    e_id_nxt     = e_id_r;
    e_energy_nxt = e_energy_r;
    if (hit && earlier) begin
      e_time_nxt   = cell_time;
      e_id_nxt     = cell_id;
      e_energy_nxt = cell_energy;
    end
    top_id_nxt = (ins && gt[0]) ? cell_id : top_id_r;
    any_nxt    = any_r | hit;
  end

  assign q_push                = acc & last_of_event;
  assign q_rec.earliest_time   = e_time_nxt;
  assign q_rec.earliest_id     = e_id_nxt;
  assign q_rec.earliest_energy = e_energy_nxt;
  assign q_rec.top_id          = top_id_nxt;
  assign q_rec.any_hit         = any_nxt;
  assign q_top_e               = top_e_nxt;
  assign q_top_t               = top_t_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      e_time_r   <= cets_pkg::TIME_SENTINEL;
      e_id_r     <= '0;
      e_energy_r <= '0;
      top_id_r   <= '0;
      any_r      <= 1'b0;
      top_e_r    <= '0;
      top_t_r    <= '0;
    end else if (acc) begin
      e_time_r   <= e_time_nxt;
      e_id_r     <= e_id_nxt;
      e_energy_r <= e_energy_nxt;
      top_id_r   <= top_id_nxt;
      any_r      <= any_nxt;
      top_e_r    <= top_e_nxt;
      top_t_r    <= top_t_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/cets_evq.sv -----
// Short queue of closed event records between front and back.
`default_nettype none
module cets_evq #(
  parameter int TOP_COUNT = 3
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  push,
  input  wire cets_pkg::evt_rec_t                    wr_rec,
  input  wire cets_pkg::energy_t [TOP_COUNT-1:0]     wr_top_e,
  input  wire cets_pkg::time_t   [TOP_COUNT-1:0]     wr_top_t,
  output logic                                       full,
  output logic                                       empty,
  input  wire logic                                  pop,
  output cets_pkg::evt_rec_t                         rd_rec,
  output cets_pkg::energy_t [TOP_COUNT-1:0]          rd_top_e,
  output cets_pkg::time_t   [TOP_COUNT-1:0]          rd_top_t
);

  cets_pkg::evt_rec_t                 rec_mem  [cets_pkg::EVQ_DEPTH];
  cets_pkg::energy_t [TOP_COUNT-1:0]  tope_mem [cets_pkg::EVQ_DEPTH];
  cets_pkg::time_t   [TOP_COUNT-1:0]  topt_mem [cets_pkg::EVQ_DEPTH];
  logic [cets_pkg::EVQ_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [cets_pkg::EVQ_CNT_W-1:0]     cnt_r;
  logic                               do_push, do_pop;

  assign full     = cnt_r == cets_pkg::EVQ_CNT_W'(cets_pkg::EVQ_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign rd_rec   = rec_mem[rd_ptr_r];
  assign rd_top_e = tope_mem[rd_ptr_r];
  assign rd_top_t = topt_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      rec_mem[wr_ptr_r]  <= wr_rec;
      tope_mem[wr_ptr_r] <= wr_top_e;
      topt_mem[wr_ptr_r] <= wr_top_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/cets_back.sv -----
// Back end: per-event method select, weighted mean with iterative divide, result register.
`default_nettype none
module cets_back #(
  parameter int TOP_COUNT = 3
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire cets_pkg::cfg_t                        cfg,
  input  wire logic                                  q_empty,
  input  wire cets_pkg::evt_rec_t                    q_rec,
  input  wire cets_pkg::energy_t [TOP_COUNT-1:0]     q_top_e,
  input  wire cets_pkg::time_t   [TOP_COUNT-1:0]     q_top_t,
  output logic                                       q_pop,
  input  wire logic                                  res_pop,
  output logic                                       res_valid,
  output cets_pkg::result_t                          res
);

  localparam int CNT_W = $clog2(TOP_COUNT + 1);
  localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int SUM_W = cets_pkg::PROD_W + CNT_W;
  localparam int DEN_W = cets_pkg::ENERGY_W + CNT_W;
  localparam int DIV_W = SUM_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_PREP, S_ROUND, S_DIV, S_OUT
  } state_t;

  state_t                               state_r;
  logic                                 res_valid_r;
  cets_pkg::result_t                    res_r;
  cets_pkg::quality_t                   held_q_r;
  cets_pkg::id_t                        held_id_r;
  cets_pkg::energy_t                    held_e_r;
  logic [CNT_W-1:0]                     cnt_r;
  logic signed [cets_pkg::PROD_W-1:0]   prod_r;
  logic                                 prod_v_r;
  logic signed [SUM_W-1:0]              num_r;
  logic [DEN_W-1:0]                     den_r;
  logic [DIV_W-1:0]                     rem_r, div_sh_r;
  logic [cets_pkg::TIME_W-1:0]          quot_r;
  logic [cets_pkg::QSTEP_W-1:0]         step_r;
  logic                                 neg_r, err_r;
  logic                                 slot_free, simple_method;
  cets_pkg::quality_t                   qual;
  cets_pkg::energy_t                    mac_e;
  cets_pkg::time_t                      mac_t;

  assign slot_free     = !res_valid_r || res_pop;
  assign simple_method = (cfg.method == cets_pkg::METHOD_EARLIEST) ||
                         (cfg.method == cets_pkg::METHOD_ENERGETIC);
  assign mac_e         = q_top_e[cnt_r[IDX_W-1:0]];
  assign mac_t         = q_top_t[cnt_r[IDX_W-1:0]];
  assign res_valid     = res_valid_r;
  assign res           = res_r;

  always_comb begin
    if (!q_rec.any_hit) begin
      qual = cets_pkg::QUALITY_NONE;
    end else if (q_top_e[0] > cfg.thr_high) begin
      qual = cets_pkg::QUALITY_HIGH;
    end else if (q_top_e[0] > cfg.thr_low) begin
      qual = cets_pkg::QUALITY_MID;
    end else begin
      qual = cets_pkg::QUALITY_LOW;
    end
  end

  always_comb begin
    q_pop = 1'b0;
    if (slot_free) begin
      q_pop = ((state_r == S_IDLE) && !q_empty && simple_method) || (state_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      held_q_r    <= '0;
      held_id_r   <= '0;
      held_e_r    <= '0;
    end else begin
      if (res_pop) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            if (!simple_method) begin
              cnt_r    <= '0;
              num_r    <= '0;
              den_r    <= '0;
              prod_v_r <= 1'b0;
              err_r    <= 1'b0;
              state_r  <= S_MAC;
            end else if (slot_free) begin
              res_valid_r <= 1'b1;
              res_r.divide_error <= 1'b0;
              if (cfg.method == cets_pkg::METHOD_EARLIEST) begin
                res_r.event_time         <= q_rec.earliest_time;
                res_r.region             <= cets_pkg::region_of(q_rec.earliest_id);
                res_r.quality_flag       <= held_q_r;
                res_r.chosen_cell_id     <= q_rec.earliest_id;
                res_r.chosen_cell_energy <= q_rec.earliest_energy;
                held_id_r                <= q_rec.earliest_id;
                held_e_r                 <= q_rec.earliest_energy;
              end else begin
                res_r.event_time         <= q_top_t[0];
                res_r.region             <= cets_pkg::region_of(q_rec.top_id);
                res_r.quality_flag       <= qual;
                res_r.chosen_cell_id     <= q_rec.top_id;
                res_r.chosen_cell_energy <= q_top_e[0];
                held_q_r                 <= qual;
                held_id_r                <= q_rec.top_id;
                held_e_r                 <= q_top_e[0];
              end
            end
          end
        end
        S_MAC: begin
          if (prod_v_r) begin
            num_r <= num_r + SUM_W'(prod_r);
          end
          if (cnt_r < CNT_W'(TOP_COUNT)) begin
            prod_r   <= $signed({1'b0, mac_e}) * mac_t;
            prod_v_r <= 1'b1;
            den_r    <= den_r + DEN_W'(mac_e);
            cnt_r    <= cnt_r + 1'b1;
          end else begin
            prod_v_r <= 1'b0;
            state_r  <= S_PREP;
          end
        end
        S_PREP: begin
          neg_r  <= num_r[SUM_W-1];
          rem_r  <= num_r[SUM_W-1] ? DIV_W'($unsigned(-num_r)) : DIV_W'($unsigned(num_r));
          quot_r <= '0;
          if (den_r == '0) begin
            err_r   <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          rem_r    <= rem_r + DIV_W'(den_r >> 1);
          div_sh_r <= DIV_W'(den_r) << (cets_pkg::TIME_W - 1);
          step_r   <= cets_pkg::QSTEP_W'(cets_pkg::TIME_W - 1);
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (rem_r >= div_sh_r) begin
            rem_r  <= rem_r - div_sh_r;
            quot_r <= {quot_r[cets_pkg::TIME_W-2:0], 1'b1};
          end else begin
            quot_r <= {quot_r[cets_pkg::TIME_W-2:0], 1'b0};
          end
          div_sh_r <= div_sh_r >> 1;
          if (step_r == '0) begin
            state_r <= S_OUT;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            res_valid_r              <= 1'b1;
            res_r.event_time         <= neg_r ? -$signed(quot_r) : $signed(quot_r);
            res_r.region             <= cets_pkg::region_of(q_rec.top_id);
            res_r.quality_flag       <= held_q_r;
            res_r.chosen_cell_id     <= held_id_r;
            res_r.chosen_cell_energy <= held_e_r;
            res_r.divide_error       <= err_r;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/calorimeter_event_timing_select_unit.sv -----
// Top level: configuration registers, front end, event queue and back end.
// Hits are taken at one per cycle while the event queue has room; an event closes on its last item.
// Earliest and most energetic: result registered from the queued record once the slot is free.
// Weighted method: the result follows the multiply-accumulate pass and the
// 18-step restoring divider; one more closed event may queue meanwhile.
// Synchronous active-low reset clears selections, held values, queue pointers and state at once.
`default_nettype none
module calorimeter_event_timing_select_unit #(
  parameter int TOP_COUNT = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_hit_present,
  input  wire logic                 in_last_of_event,
  input  wire logic [9:0]           in_cell_id,
  input  wire logic [15:0]          in_cell_energy,
  input  wire logic signed [17:0]   in_cell_time,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic signed [17:0]        out_event_time,
  output logic [1:0]                out_region,
  output logic [1:0]                out_quality_flag,
  output logic [9:0]                out_chosen_cell_id,
  output logic [15:0]               out_chosen_cell_energy,
  output logic                      out_divide_error,
  input  wire logic                 cfg_wr_en,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);

  cets_pkg::cfg_t                     cfg_r;
  logic                               acc, q_push, q_full, q_empty, q_pop, res_valid;
  cets_pkg::evt_rec_t                 wr_rec, rd_rec;
  cets_pkg::energy_t [TOP_COUNT-1:0]  wr_top_e, rd_top_e;
  cets_pkg::time_t   [TOP_COUNT-1:0]  wr_top_t, rd_top_t;
  cets_pkg::result_t                  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.method   <= cets_pkg::RST_METHOD;
      cfg_r.thr_low  <= cets_pkg::RST_THR_LOW;
      cfg_r.thr_high <= cets_pkg::RST_THR_HIGH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cets_pkg::CFG_IDX_METHOD:   cfg_r.method   <= cfg_data[1:0];
        cets_pkg::CFG_IDX_THR_LOW:  cfg_r.thr_low  <= cfg_data;
        cets_pkg::CFG_IDX_THR_HIGH: cfg_r.thr_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_full = q_full;
  assign acc     = in_push & ~q_full;

  cets_front #(.TOP_COUNT(TOP_COUNT)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .hit_present   (in_hit_present),
    .last_of_event (in_last_of_event),
    .cell_id       (in_cell_id),
    .cell_energy   (in_cell_energy),
    .cell_time     (in_cell_time),
    .q_push        (q_push),
    .q_rec         (wr_rec),
    .q_top_e       (wr_top_e),
    .q_top_t       (wr_top_t)
  );

  cets_evq #(.TOP_COUNT(TOP_COUNT)) u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_rec   (wr_rec),
    .wr_top_e (wr_top_e),
    .wr_top_t (wr_top_t),
    .full     (q_full),
    .empty    (q_empty),
    .pop      (q_pop),
    .rd_rec   (rd_rec),
    .rd_top_e (rd_top_e),
    .rd_top_t (rd_top_t)
  );

  cets_back #(.TOP_COUNT(TOP_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_rec     (rd_rec),
    .q_top_e   (rd_top_e),
    .q_top_t   (rd_top_t),
    .q_pop     (q_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_empty              = ~res_valid;
  assign out_event_time         = res.event_time;
  assign out_region             = res.region;
  assign out_quality_flag       = res.quality_flag;
  assign out_chosen_cell_id     = res.chosen_cell_id;
  assign out_chosen_cell_energy = res.chosen_cell_energy;
  assign out_divide_error       = res.divide_error;

endmodule
`default_nettype wire
